[rtl/tmbv_pkg.sv]
`timescale 1ns / 1ps

package tmbv_pkg;

  localparam int SAMPLE_COUNT  = 20;
  localparam int TRIM_EACH_END = 5;

  localparam int SAMPLE_W = 12;
  localparam int MV_W     = 15;

  localparam int ADDR_W = $clog2(SAMPLE_COUNT);
  localparam int CNT_W  = $clog2(SAMPLE_COUNT + 1);
  localparam int SUM_W  = SAMPLE_W + CNT_W;

  // kept middle range, [MID_LO, MID_HI), empty when the trim covers everything
  localparam int MID_HI = (SAMPLE_COUNT > TRIM_EACH_END) ? SAMPLE_COUNT - TRIM_EACH_END : 0;
  localparam int MID_LO = (TRIM_EACH_END < MID_HI) ? TRIM_EACH_END : MID_HI;

  // serial divider for the mean
  localparam int DVD_W  = SUM_W;
  localparam int DSR_W  = CNT_W;
  localparam int STEP_W = $clog2(DVD_W);

  localparam int COE_W = 8;

  localparam int COE_MUL = 140;
  localparam int COE_DIV = 2296;
  localparam int PIN_MUL = 3300;
  localparam int PIN_DIV = 4095;
  localparam int MV_MUL  = 1200;
  localparam int MV_DIV  = 185;

  // reciprocals rounded up; the shifts keep each quotient exact over the input range
  localparam int COE_SH = 24;
  localparam int PIN_SH = 24;
  localparam int MV_SH  = 18;

  localparam longint COE_RCP = ((longint'(COE_MUL) << COE_SH) + COE_DIV - 1) / COE_DIV;
  localparam longint PIN_RCP = ((longint'(PIN_MUL) << PIN_SH) + PIN_DIV - 1) / PIN_DIV;
  localparam longint MV_RCP  = ((longint'(MV_MUL) << MV_SH) + MV_DIV - 1) / MV_DIV;

  localparam int COE_PROD_W = SAMPLE_W + $clog2(COE_RCP + 1);
  localparam int PIN_PROD_W = SAMPLE_W + $clog2(PIN_RCP + 1);
  localparam int MV_PROD_W  = SAMPLE_W + $clog2(MV_RCP + 1);

endpackage

[rtl/trimmed_mean_battery_voltage.sv]
`timescale 1ns / 1ps

// channel  ports                                          handshake
// input    start, busy, in_sample                         taken when start && !busy
// result   out_valid, out_battery_mv, out_no_valid_samples one-cycle strobe
//
// an item is inserted into the sorted sample memory directly when the store
// is empty, else by shifting each larger held sample up (one memory read a cycle)
// after the last item of a burst: middle-range read pass, then if any kept sample
// is nonzero a 17-step divider and the S_COE and S_MV scaling states
// rst_n is synchronous and clears control only; the sample memory is not cleared
// the result strobe cannot be stalled; busy stays high until the result is shown
module trimmed_mean_battery_voltage
  import tmbv_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [SAMPLE_W-1:0] in_sample,
  output logic                out_valid,
  output logic [MV_W-1:0]     out_battery_mv,
  output logic                out_no_valid_samples
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_PLACE,
    S_ACC,
    S_DIV,
    S_COE,
    S_MV,
    S_OUT
  } state_t;

  logic [SAMPLE_W-1:0] mem [SAMPLE_COUNT];
  logic [SAMPLE_W-1:0] rd_data_r;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_wa;
  logic [SAMPLE_W-1:0] mem_wd;
  logic [ADDR_W-1:0]   mem_ra;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]   pos_r, pos_nxt;
  logic [SAMPLE_W-1:0] v_r, v_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic                pend_r, pend_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    nz_r, nz_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [DSR_W-1:0]    rem_r, rem_nxt;
  logic [DVD_W-1:0]    quo_r, quo_nxt;
  logic [DSR_W-1:0]    dsr_r, dsr_nxt;
  logic [COE_W-1:0]    coe_r, coe_nxt;
  logic [SAMPLE_W-1:0] pin_r, pin_nxt;
  logic [MV_W-1:0]     mv_r, mv_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [MV_W-1:0]     out_mv_r, out_mv_nxt;
  logic                out_flag_r, out_flag_nxt;

  logic                  ins_done;
  logic [DSR_W:0]        rem_sh;
  logic                  rem_ge;
  logic [COE_PROD_W-1:0] coe_prod;
  logic [PIN_PROD_W-1:0] pin_prod;
  logic [MV_PROD_W-1:0]  mv_prod;

  // memory: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  // restoring divider step
  always_comb begin
    rem_sh = {rem_r, quo_r[DVD_W-1]};
    rem_ge = (rem_sh >= {1'b0, dsr_r});
  end

  // constant divisions by reciprocal multiplication
  always_comb begin
    coe_prod = COE_PROD_W'(quo_r[SAMPLE_W-1:0]) * COE_PROD_W'(COE_RCP);
    pin_prod = PIN_PROD_W'(quo_r[SAMPLE_W-1:0]) * PIN_PROD_W'(PIN_RCP);
    mv_prod  = MV_PROD_W'(pin_r) * MV_PROD_W'(MV_RCP);
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    v_nxt         = v_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    sum_nxt       = sum_r;
    nz_nxt        = nz_r;
    step_nxt      = step_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    dsr_nxt       = dsr_r;
    coe_nxt       = coe_r;
    pin_nxt       = pin_r;
    mv_nxt        = mv_r;
    out_valid_nxt = 1'b0;
    out_mv_nxt    = out_mv_r;
    out_flag_nxt  = out_flag_r;
    mem_we        = 1'b0;
    mem_wa        = pos_r;
    mem_wd        = v_r;
    mem_ra        = '0;
    ins_done      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          v_nxt   = in_sample;
          pos_nxt = ADDR_W'(cnt_r);
          if (cnt_r == '0) begin
            mem_we   = 1'b1;
            mem_wa   = '0;
            mem_wd   = in_sample;
            ins_done = 1'b1;
          end else begin
            mem_ra    = ADDR_W'(cnt_r - CNT_W'(1));
            state_nxt = S_SHIFT;
          end
        end
      end

      S_SHIFT: begin
        mem_we = 1'b1;
        mem_wa = pos_r;
        if (rd_data_r > v_r) begin
          mem_wd  = rd_data_r;
          pos_nxt = pos_r - ADDR_W'(1);
          if (pos_r == ADDR_W'(1)) begin
            state_nxt = S_PLACE;
          end else begin
            mem_ra = pos_r - ADDR_W'(2);
          end
        end else begin
          mem_wd   = v_r;
          ins_done = 1'b1;
        end
      end

      S_PLACE: begin
        mem_we   = 1'b1;
        mem_wa   = pos_r;
        mem_wd   = v_r;
        ins_done = 1'b1;
      end

      S_ACC: begin
        if (pend_r && (rd_data_r != '0)) begin
          sum_nxt = sum_r + SUM_W'(rd_data_r);
          nz_nxt  = nz_r + CNT_W'(1);
        end
        if (idx_r < CNT_W'(MID_HI)) begin
          mem_ra   = idx_r[ADDR_W-1:0];
          idx_nxt  = idx_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            if (nz_r == '0) begin
              out_valid_nxt = 1'b1;
              out_mv_nxt    = '0;
              out_flag_nxt  = 1'b1;
              cnt_nxt       = '0;
              state_nxt     = S_IDLE;
            end else begin
              quo_nxt   = DVD_W'(sum_r);
              dsr_nxt   = DSR_W'(nz_r);
              rem_nxt   = '0;
              step_nxt  = '0;
              state_nxt = S_DIV;
            end
          end
        end
      end

      S_DIV: begin
        rem_nxt  = rem_ge ? DSR_W'(rem_sh - {1'b0, dsr_r}) : rem_sh[DSR_W-1:0];
        quo_nxt  = {quo_r[DVD_W-2:0], rem_ge};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DVD_W - 1)) begin
          state_nxt = S_COE;
        end
      end

      S_COE: begin
        coe_nxt   = coe_prod[COE_SH +: COE_W];
        pin_nxt   = pin_prod[PIN_SH +: SAMPLE_W];
        state_nxt = S_MV;
      end

      S_MV: begin
        mv_nxt    = mv_prod[MV_SH +: MV_W];
        state_nxt = S_OUT;
      end

      S_OUT: begin
        out_valid_nxt = 1'b1;
        out_mv_nxt    = mv_r + MV_W'(coe_r);
        out_flag_nxt  = 1'b0;
        cnt_nxt       = '0;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // end of an insertion: either wait for the next item or reduce the burst
    if (ins_done) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(SAMPLE_COUNT - 1)) begin
        idx_nxt   = CNT_W'(MID_LO);
        pend_nxt  = 1'b0;
        sum_nxt   = '0;
        nz_nxt    = '0;
        state_nxt = S_ACC;
      end else begin
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r      <= pos_nxt;
    v_r        <= v_nxt;
    idx_r      <= idx_nxt;
    sum_r      <= sum_nxt;
    nz_r       <= nz_nxt;
    step_r     <= step_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    dsr_r      <= dsr_nxt;
    coe_r      <= coe_nxt;
    pin_r      <= pin_nxt;
    mv_r       <= mv_nxt;
    out_mv_r   <= out_mv_nxt;
    out_flag_r <= out_flag_nxt;
  end

  assign busy                 = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_battery_mv       = out_mv_r;
  assign out_no_valid_samples = out_flag_r;

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb
  import tmbv_pkg::*;
();

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    int                  idle_pct;
    bit                  wait_drain;
  } sample_item_t;

  typedef struct {
    logic [MV_W-1:0] battery_mv;
    logic            no_valid_samples;
  } reading_t;

  typedef enum int {
    BURST_UNIFORM,
    BURST_FULL_SCALE,
    BURST_ZERO,
    BURST_ZERO_MIDDLE,
    BURST_SPARSE,
    BURST_NARROW,
    BURST_RISING,
    BURST_FALLING,
    BURST_OUTLIERS
  } burst_kind_t;

  localparam int RANDOM_BURSTS = 27;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic                out_valid;
  logic [MV_W-1:0]     out_battery_mv;
  logic                out_no_valid_samples;

  sample_item_t        sample_q[$];
  reading_t            reading_q[$];
  logic [SAMPLE_W-1:0] burst_sorted[SAMPLE_COUNT];
  int                  burst_fill = 0;
  int                  errors = 0;

  trimmed_mean_battery_voltage dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_sample            (in_sample),
    .out_valid            (out_valid),
    .out_battery_mv       (out_battery_mv),
    .out_no_valid_samples (out_no_valid_samples)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // sorted insert, and the trimmed mean voltage once the burst is full
  task automatic take_sample(input logic [SAMPLE_W-1:0] s);
    int          pos;
    int unsigned total;
    int unsigned nonzero;
    int unsigned avg;
    reading_t    r;
    pos = burst_fill;
    while (pos > 0 && burst_sorted[pos-1] > s) begin
      burst_sorted[pos] = burst_sorted[pos-1];
      pos--;
    end
    burst_sorted[pos] = s;
    burst_fill++;
    if (burst_fill == SAMPLE_COUNT) begin
      total = 0;
      nonzero = 0;
      for (int i = TRIM_EACH_END; i + TRIM_EACH_END < SAMPLE_COUNT; i++) begin
        if (burst_sorted[i] != 0) begin
          total += burst_sorted[i];
          nonzero++;
        end
      end
      if (nonzero == 0) begin
        r.battery_mv = '0;
        r.no_valid_samples = 1'b1;
      end else begin
        avg = total / nonzero;
        r.battery_mv = MV_W'((140 * avg) / 2296 + (1200 * ((3300 * avg) / 4095)) / 185);
        r.no_valid_samples = 1'b0;
      end
      reading_q.push_back(r);
      burst_fill = 0;
    end
  endtask

  task automatic add_burst(input burst_kind_t kind, input int idle_pct, input bit drain);
    logic [SAMPLE_W-1:0] vals[SAMPLE_COUNT];
    logic [SAMPLE_W-1:0] tmp;
    int                  base;
    int                  step;
    int                  j;
    sample_item_t        item;
    step = $urandom_range(0, 200);
    base = $urandom_range(0, 4095 - (SAMPLE_COUNT - 1) * step);
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      case (kind)
        BURST_FULL_SCALE:  vals[i] = 12'hfff;
        BURST_ZERO:        vals[i] = '0;
        BURST_ZERO_MIDDLE: vals[i] = (i < SAMPLE_COUNT - TRIM_EACH_END) ? '0 :
                                     SAMPLE_W'($urandom_range(1, 4095));
        BURST_SPARSE:      vals[i] = ($urandom_range(0, 1) == 1) ? '0 :
                                     SAMPLE_W'($urandom_range(1, 4095));
        BURST_NARROW:      vals[i] = SAMPLE_W'(base % 4000 + $urandom_range(0, 95));
        BURST_RISING:      vals[i] = SAMPLE_W'(base + i * step);
        BURST_FALLING:     vals[i] = SAMPLE_W'(base + (SAMPLE_COUNT - 1 - i) * step);
        BURST_OUTLIERS: begin
          if (i < TRIM_EACH_END) vals[i] = '0;
          else if (i < 2 * TRIM_EACH_END) vals[i] = 12'hfff;
          else vals[i] = SAMPLE_W'($urandom_range(1, 4095));
        end
        default:           vals[i] = SAMPLE_W'($urandom_range(0, 4095));
      endcase
    end
    if (kind != BURST_RISING && kind != BURST_FALLING) begin
      for (int i = SAMPLE_COUNT - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = vals[i];
        vals[i] = vals[j];
        vals[j] = tmp;
      end
    end
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      item.sample = vals[i];
      item.idle_pct = idle_pct;
      item.wait_drain = drain && (i == 0);
      sample_q.push_back(item);
    end
  endtask

  always @(posedge clk) begin : driver
    logic free;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      free = !start;
      if (start && !busy) begin
        take_sample(in_sample);
        void'(sample_q.pop_front());
        free = 1'b1;
      end
      if (free) begin
        if (sample_q.size() != 0 && !(sample_q[0].wait_drain && reading_q.size() != 0) &&
            $urandom_range(0, 99) >= sample_q[0].idle_pct) begin
          start <= 1'b1;
          in_sample <= sample_q[0].sample;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    reading_t want;
    if (rst_n && out_valid) begin
      if (reading_q.size() == 0) begin
        $error("unexpected result: battery_mv %0d no_valid_samples %0d",
               out_battery_mv, out_no_valid_samples);
        errors++;
      end else begin
        want = reading_q.pop_front();
        if (out_battery_mv !== want.battery_mv) begin
          $error("battery_mv: expected %0d, got %0d", want.battery_mv, out_battery_mv);
          errors++;
        end
        if (out_no_valid_samples !== want.no_valid_samples) begin
          $error("no_valid_samples: expected %0d, got %0d",
                 want.no_valid_samples, out_no_valid_samples);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [SAMPLE_W-1:0] directed[SAMPLE_COUNT] = '{
      12'hfff, 12'hffe, 12'h800, 12'h001, 12'h000, 12'h000, 12'haaa, 12'h555,
      12'hfff, 12'h000, 12'hbb8, 12'h064, 12'h000, 12'hfff, 12'h002, 12'h000,
      12'h7ff, 12'hfff, 12'h001, 12'h000
    };
    sample_item_t item;
    int           idle_pct;
    burst_kind_t  kind;
    // descending start forces shifting, zeros in the kept middle are skipped
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      item.sample = directed[i];
      item.idle_pct = 0;
      item.wait_drain = 1'b0;
      sample_q.push_back(item);
    end
    for (int b = 0; b < RANDOM_BURSTS; b++) begin
      if (b < 9) idle_pct = 0;
      else if (b < 18) idle_pct = 73;
      else if (b < 27) idle_pct = 35;
      else idle_pct = 0;
      case (b)
        0:       kind = BURST_FULL_SCALE;
        1:       kind = BURST_ZERO;
        2:       kind = BURST_ZERO_MIDDLE;
        3:       kind = BURST_OUTLIERS;
        default: kind = burst_kind_t'($urandom_range(0, 8));
      endcase
      add_burst(kind, idle_pct, (b % 9 == 0) && b != 0);
    end
    wait (rst_n);
    while (sample_q.size() != 0 || start) @(posedge clk);
    while (reading_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && reading_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
